FILE: src/mcaw_pkg.sv
// Shared types, register codes and mode tables of the micro-tile copy address walker.
package mcaw_pkg;

  localparam logic [12:0] MAX_DIM = 13'd4096;

  typedef enum logic [2:0] {
    CFG_PIXEL_SIZE_MODE = 3'd0,
    CFG_COPY_DIRECTION  = 3'd1,
    CFG_LINEAR_STRIDE   = 3'd2,
    CFG_TILED_STRIDE    = 3'd3,
    CFG_BOX_LEFT        = 3'd4,
    CFG_BOX_TOP         = 3'd5,
    CFG_BOX_WIDTH       = 3'd6,
    CFG_BOX_HEIGHT      = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PIX_1B = 2'd0,
    PIX_2B = 2'd1,
    PIX_4B = 2'd2,
    PIX_8B = 2'd3
  } pix_mode_t;

  localparam logic DIR_LOAD  = 1'b0;
  localparam logic DIR_STORE = 1'b1;

  localparam pix_mode_t PIX_MODE_RST = PIX_4B;

  // One tile worth of row descriptors, handed from the address stage to the row emitter.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] src_step;
    logic [15:0] dst_step;
    logic [4:0]  row_length;
    logic [2:0]  last_idx;
    logic        last_tile;
  } tile_desc_t;

  function automatic logic [4:0] row_len(input pix_mode_t mode);
    if (mode == PIX_1B) return 5'd8;
    return 5'd16;
  endfunction

  function automatic logic [3:0] tile_w(input pix_mode_t mode);
    logic [3:0] w;
    unique case (mode)
      PIX_1B: w = 4'd8;
      PIX_2B: w = 4'd8;
      PIX_4B: w = 4'd4;
      PIX_8B: w = 4'd2;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] tile_h(input pix_mode_t mode);
    if (mode == PIX_1B) return 4'd8;
    return 4'd4;
  endfunction

endpackage

FILE: src/mcaw_ifs.sv
// Valid/ready channel interfaces of the micro-tile copy address walker.
interface mcaw_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface mcaw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [4:0]  row_length;
  logic        tile_last_row;
  logic        box_done;
  modport source (output valid, output src_addr, output dst_addr, output row_length,
                  output tile_last_row, output box_done, input ready);
  modport sink (input valid, input src_addr, input dst_addr, input row_length,
                input tile_last_row, input box_done, output ready);
endinterface

interface mcaw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/mcaw_row_gen.sv
// Row emitter: steps through the rows of one tile and holds the result register.
module mcaw_row_gen import mcaw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       desc_valid,
  input  tile_desc_t desc,
  output logic       desc_ready,
  mcaw_out_if.source out_ch
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [15:0] src_step_r;
  logic [15:0] dst_step_r;
  logic [4:0]  rlen_r;
  logic [2:0]  last_idx_r;
  logic [2:0]  idx_r;
  logic        last_tile_r;
  logic        last_row_r;
  logic        out_fire;
  logic        load;

  assign out_fire   = valid_r && out_ch.ready;
  assign desc_ready = !valid_r || (out_fire && last_row_r);
  assign load       = desc_valid && desc_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_fire && last_row_r) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      src_r       <= desc.src;
      dst_r       <= desc.dst;
      src_step_r  <= desc.src_step;
      dst_step_r  <= desc.dst_step;
      rlen_r      <= desc.row_length;
      last_idx_r  <= desc.last_idx;
      last_tile_r <= desc.last_tile;
      idx_r       <= 3'd0;
      last_row_r  <= 1'b0;
    end else if (out_fire && !last_row_r) begin
      src_r      <= src_r + 32'(src_step_r);
      dst_r      <= dst_r + 32'(dst_step_r);
      idx_r      <= idx_r + 3'd1;
      last_row_r <= (idx_r + 3'd1) == last_idx_r;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.src_addr      = src_r;
  assign out_ch.dst_addr      = dst_r;
  assign out_ch.row_length    = rlen_r;
  assign out_ch.tile_last_row = last_row_r;
  assign out_ch.box_done      = last_row_r && last_tile_r;

endmodule

FILE: src/microtile_copy_address_walker.sv
// Top level of the micro-tile copy address walker.
//
//   channel  direction  payload                                              role
//   cfg_ch   in         index[2:0], data[15:0]                               register write
//   in_ch    in         restart                                              tile request
//   out_ch   out        src_addr, dst_addr, row_length, tile_last_row,       row descriptor
//                       box_done
//
// A request is registered, its two base offsets are formed in the next cycle by one
// multiplier per side, and the row emitter then issues one row per cycle unless the output
// stalls: 8 rows for 1-byte pixels, 4 otherwise. Rows of the next tile follow without a
// gap, so the rate is set by the output, one transfer per cycle. An empty box consumes the
// request and emits nothing. Reset restores the config registers and puts the walk position
// at the box origin. A stalled output holds its row and backs up into the request side.
module microtile_copy_address_walker import mcaw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mcaw_cfg_if.sink  cfg_ch,
  mcaw_in_if.sink   in_ch,
  mcaw_out_if.source out_ch
);

  pix_mode_t   pix_mode_r;
  logic        dir_r;
  logic [15:0] lin_stride_r;
  logic [15:0] til_stride_r;
  logic [11:0] box_left_r;
  logic [11:0] box_top_r;
  logic [12:0] box_w_r;
  logic [12:0] box_h_r;

  logic [12:0] cur_col_r, cur_col_nxt;
  logic [12:0] cur_row_r, cur_row_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic [12:0] s1_col_r;
  logic [12:0] s1_row_r;
  logic        s1_last_r;

  logic [12:0] bw, bh;
  logic [12:0] col0, row0, col1, row1;
  logic [12:0] nc_sum, nr_sum;
  logic        empty_box;
  logic        wrap_col, wrap_row;
  logic        in_fire;

  logic [12:0] tiled_row;
  logic [12:0] tiled_col;
  logic [17:0] tiled_col_sh;
  logic [28:0] tiled_prod;
  logic [28:0] linear_prod;
  logic [15:0] linear_col_sh;
  logic [31:0] tiled_base;
  logic [31:0] linear_base;
  logic [4:0]  rlen;
  tile_desc_t  desc;
  logic        desc_ready;

  // Register file.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_mode_r   <= PIX_MODE_RST;
      dir_r        <= DIR_LOAD;
      lin_stride_r <= '0;
      til_stride_r <= '0;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_w_r      <= '0;
      box_h_r      <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_PIXEL_SIZE_MODE: pix_mode_r   <= pix_mode_t'(cfg_ch.data[1:0]);
        CFG_COPY_DIRECTION:  dir_r        <= cfg_ch.data[0];
        CFG_LINEAR_STRIDE:   lin_stride_r <= cfg_ch.data;
        CFG_TILED_STRIDE:    til_stride_r <= cfg_ch.data;
        CFG_BOX_LEFT:        box_left_r   <= cfg_ch.data[11:0];
        CFG_BOX_TOP:         box_top_r    <= cfg_ch.data[11:0];
        CFG_BOX_WIDTH:       box_w_r      <= cfg_ch.data[12:0];
        CFG_BOX_HEIGHT:      box_h_r      <= cfg_ch.data[12:0];
      endcase
    end
  end

  // Walk position and the step to the next tile.
  assign bw        = (box_w_r > MAX_DIM) ? MAX_DIM : box_w_r;
  assign bh        = (box_h_r > MAX_DIM) ? MAX_DIM : box_h_r;
  assign empty_box = (bw == 13'd0) || (bh == 13'd0);
  assign col0      = in_ch.restart ? 13'd0 : cur_col_r;
  assign row0      = in_ch.restart ? 13'd0 : cur_row_r;
  assign col1      = (col0 >= bw || row0 >= bh) ? 13'd0 : col0;
  assign row1      = (col0 >= bw || row0 >= bh) ? 13'd0 : row0;
  assign nc_sum    = col1 + 13'(tile_w(pix_mode_r));
  assign nr_sum    = row1 + 13'(tile_h(pix_mode_r));
  assign wrap_col  = nc_sum >= bw;
  assign wrap_row  = wrap_col && (nr_sum >= bh);

  assign in_ch.ready = !s1_valid_r || desc_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    s1_valid_nxt = s1_valid_r && !desc_ready;
    if (in_fire) begin
      if (empty_box) begin
        cur_col_nxt = col0;
        cur_row_nxt = row0;
      end else begin
        s1_valid_nxt = 1'b1;
        cur_col_nxt  = wrap_col ? 13'd0 : nc_sum;
        cur_row_nxt  = wrap_col ? (wrap_row ? 13'd0 : nr_sum) : row1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !empty_box) begin
      s1_col_r  <= col1;
      s1_row_r  <= row1;
      s1_last_r <= wrap_row;
    end
  end

  // Base offsets of the tile on both sides.
  assign tiled_row   = 13'(box_top_r) + s1_row_r;
  assign tiled_col   = 13'(box_left_r) + s1_col_r;
  assign tiled_prod  = tiled_row * til_stride_r;
  assign linear_prod = s1_row_r * lin_stride_r;

  always_comb begin
    unique case (pix_mode_r)
      PIX_1B: tiled_col_sh = {2'b00, tiled_col, 3'b000};
      PIX_2B: tiled_col_sh = {2'b00, tiled_col, 3'b000};
      PIX_4B: tiled_col_sh = {1'b0, tiled_col, 4'b0000};
      PIX_8B: tiled_col_sh = {tiled_col, 5'b00000};
    endcase
  end

  assign linear_col_sh = 16'(s1_col_r) << pix_mode_r;
  assign tiled_base    = 32'(tiled_prod) + 32'(tiled_col_sh);
  assign linear_base   = 32'(linear_prod) + 32'(linear_col_sh);
  assign rlen          = row_len(pix_mode_r);

  always_comb begin
    desc.row_length = rlen;
    desc.last_idx   = 3'(tile_h(pix_mode_r) - 4'd1);
    desc.last_tile  = s1_last_r;
    if (dir_r == DIR_STORE) begin
      desc.src      = linear_base;
      desc.dst      = tiled_base;
      desc.src_step = lin_stride_r;
      desc.dst_step = 16'(rlen);
    end else begin
      desc.src      = tiled_base;
      desc.dst      = linear_base;
      desc.src_step = 16'(rlen);
      desc.dst_step = lin_stride_r;
    end
  end

  mcaw_row_gen u_row_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (s1_valid_r),
    .desc       (desc),
    .desc_ready (desc_ready),
    .out_ch     (out_ch)
  );

endmodule

FILE: src/mcaw_checker.sv
// Port-level assertions of the micro-tile copy address walker and their binding.
module mcaw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] src_addr,
  input logic [31:0] dst_addr,
  input logic [4:0]  row_length,
  input logic        tile_last_row,
  input logic        box_done
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(src_addr) && $stable(dst_addr))
    else $error("row descriptor changed while stalled");

  a_done_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && box_done |-> tile_last_row)
    else $error("box completion flagged on a row that does not end a tile");

  a_row_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (row_length == 5'd8 || row_length == 5'd16))
    else $error("row length is neither 8 nor 16");

  a_tile_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !tile_last_row |=> out_valid && $stable(row_length))
    else $error("tile ended before its last row was transferred");

endmodule

bind microtile_copy_address_walker mcaw_checker u_mcaw_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .src_addr      (out_ch.src_addr),
  .dst_addr      (out_ch.dst_addr),
  .row_length    (out_ch.row_length),
  .tile_last_row (out_ch.tile_last_row),
  .box_done      (out_ch.box_done)
);
